FILE: sv/mce_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the masked composition enumerator
// no dependencies; imported by mce_step and the top level

package mce_pkg;

  // fixed field widths of the stream payloads
  localparam int TOTAL_W = 8;
  localparam int MASK_W  = 8;
  localparam int LANE_W  = 8;
  localparam int OUT_W   = 64;

  // op codes carried on the input tuser
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // status codes carried on the output tuser
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // outcome of one step, from the step logic to the result register
  typedef struct packed {
    logic is_last;
    logic err;
  } step_res_t;

endpackage

FILE: sv/masked_composition_enumerator_top.sv
`timescale 1ns / 1ps
// top level of the masked composition enumerator: input register, step logic, result register
// depends on mce_pkg and mce_step
//
// usage
//   slave stream takes one item per handshake: tuser is the op (start or advance),
//   tdata holds total in bits 7:0 and the position mask in bits 15:8
//   a start loads the total at the lowest selected position; each advance emits
//   the next composition of the total over the selected positions
//   master stream gives one result per item: tdata is eight 8-bit counts,
//   tlast marks the final vector, tuser is the status (0 ok, 1 error)
//   an error result carries zero data and leaves the enumeration state untouched
// timing
//   a result passes from the input register through the step logic into the result register;
//   one item per cycle sustained while the master side takes results, set by the
//   combinational step logic that reads and writes the enumeration state
// reset
//   clears the pending input, the pending result and the enumeration state, so
//   an advance before any start returns an error
// stalls
//   a held result stays on the master side; the input register still takes one
//   more item, then the slave side deasserts tready until the result is taken

module masked_composition_enumerator_top #(
  parameter int POSITIONS  = 8,
  parameter int COUNT_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // total [7:0], position_mask [15:8]
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // counts_packed [63:0]
  output logic        m_axis_tlast,   // is_last
  output logic        m_axis_tuser    // status
);
  import mce_pkg::*;

  // input register
  logic                 in_v_q, in_v_d;
  logic                 op_q;
  logic [TOTAL_W-1:0]   total_q;
  logic [MASK_W-1:0]    mask_q;

  // enumeration state
  logic [COUNT_BITS-1:0] counts_q [POSITIONS];
  logic [POSITIONS-1:0]  sel_q;
  logic                  active_q;
  logic                  done_q;

  // step outputs
  logic [COUNT_BITS-1:0] counts_d [POSITIONS];
  logic [POSITIONS-1:0]  sel_d;
  logic                  active_d;
  logic                  done_d;
  step_res_t             res;

  // result register
  logic                 out_v_q, out_v_d;
  logic [OUT_W-1:0]     data_q, data_d;
  logic                 last_q;
  logic                 status_q;

  logic                 s_fire;
  logic                 adv;

  assign adv           = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || adv;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  mce_step #(
    .POSITIONS  (POSITIONS),
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .op_i     (op_q),
    .total_i  (total_q),
    .mask_i   (mask_q),
    .counts_i (counts_q),
    .sel_i    (sel_q),
    .active_i (active_q),
    .done_i   (done_q),
    .counts_o (counts_d),
    .sel_o    (sel_d),
    .active_o (active_d),
    .done_o   (done_d),
    .res_o    (res)
  );

  // pack the new counts, zero on error
  always_comb begin
    data_d = '0;
    if (!res.err) begin
      for (int p = 0; p < POSITIONS; p++) begin
        data_d[LANE_W*p +: LANE_W] = LANE_W'(counts_d[p]);
      end
    end
  end

  always_comb begin
    in_v_d = in_v_q;
    if (s_fire) begin
      in_v_d = 1'b1;
    end else if (adv) begin
      in_v_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (adv) begin
      out_v_d = 1'b1;
    end else if (m_axis_tready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
      sel_q    <= '0;
      active_q <= 1'b0;
      done_q   <= 1'b0;
      for (int p = 0; p < POSITIONS; p++) begin
        counts_q[p] <= '0;
      end
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
      if (adv) begin
        counts_q <= counts_d;
        sel_q    <= sel_d;
        active_q <= active_d;
        done_q   <= done_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      op_q    <= s_axis_tuser;
      total_q <= s_axis_tdata[TOTAL_W-1:0];
      mask_q  <= s_axis_tdata[TOTAL_W +: MASK_W];
    end
    if (adv) begin
      data_q   <= data_d;
      last_q   <= res.is_last;
      status_q <= res.err ? STATUS_ERR : STATUS_OK;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = status_q;

  // an error result never carries data or a last flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == STATUS_ERR) |-> (m_axis_tdata == '0 && !m_axis_tlast))
    else $error("error result with nonzero payload");

  // a finished enumeration implies an active one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> active_q)
    else $error("done set without an active sequence");

  // a pending item with room downstream shows up as a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> m_axis_tvalid)
    else $error("pending item did not reach the result register");

  // a successful last vector closes the sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !res.err && res.is_last) |=> done_q)
    else $error("last vector did not mark the sequence done");

endmodule

FILE: sv/mce_step.sv
`timescale 1ns / 1ps
// next-vector logic: applies one start or advance item to the current state
// depends on mce_pkg; purely combinational, used between input and result registers

module mce_step #(
  parameter int POSITIONS  = 8,
  parameter int COUNT_BITS = 8
) (
  input  logic                           op_i,
  input  logic [mce_pkg::TOTAL_W-1:0]    total_i,
  input  logic [mce_pkg::MASK_W-1:0]     mask_i,
  input  logic [COUNT_BITS-1:0]          counts_i [POSITIONS],
  input  logic [POSITIONS-1:0]           sel_i,
  input  logic                           active_i,
  input  logic                           done_i,
  output logic [COUNT_BITS-1:0]          counts_o [POSITIONS],
  output logic [POSITIONS-1:0]           sel_o,
  output logic                           active_o,
  output logic                           done_o,
  output mce_pkg::step_res_t             res_o
);
  import mce_pkg::*;

  localparam int PW = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic [POSITIONS-1:0]  start_mask;
  logic [PW-1:0]         start_low;
  logic [COUNT_BITS-1:0] total_sat;
  logic [PW-1:0]         low;
  logic [PW-1:0]         src;
  logic                  src_found;
  logic [PW-1:0]         dst;
  logic                  dst_found;
  logic [PW-1:0]         hi;
  logic                  last;
  logic                  err;
  logic [COUNT_BITS-1:0] n_counts [POSITIONS];
  logic [POSITIONS-1:0]  n_sel;
  logic                  n_active;

  assign start_mask = mask_i[POSITIONS-1:0];
  assign total_sat  = (total_i > TOTAL_W'(CountMax)) ? CountMax : total_i[COUNT_BITS-1:0];

  // lowest selected position of the new mask and of the stored mask
  always_comb begin
    start_low = '0;
    low       = '0;
    for (int p = POSITIONS - 1; p >= 0; p--) begin
      if (start_mask[p]) start_low = PW'(p);
      if (sel_i[p]) low = PW'(p);
    end
  end

  // source is the first selected nonzero count; when the lowest count is
  // nonzero this is the lowest position itself
  always_comb begin
    src       = '0;
    src_found = 1'b0;
    for (int p = POSITIONS - 1; p >= 0; p--) begin
      if (sel_i[p] && counts_i[p] != '0) begin
        src       = PW'(p);
        src_found = 1'b1;
      end
    end
  end

  // destination is the next selected position above the source
  always_comb begin
    dst       = '0;
    dst_found = 1'b0;
    for (int p = POSITIONS - 1; p >= 0; p--) begin
      if (sel_i[p] && (p > int'(src))) begin
        dst       = PW'(p);
        dst_found = 1'b1;
      end
    end
  end

  always_comb begin
    err      = 1'b1;
    n_counts = counts_i;
    n_sel    = sel_i;
    n_active = active_i;
    if (op_i == OP_START) begin
      if (start_mask != '0) begin
        err = 1'b0;
        for (int p = 0; p < POSITIONS; p++) begin
          n_counts[p] = '0;
        end
        n_counts[start_low] = total_sat;
        n_sel               = start_mask;
        n_active            = 1'b1;
      end
    end else if (active_i && !done_i && src_found && dst_found) begin
      err = 1'b0;
      // source less one lands on the lowest position, covers both rules
      n_counts[src] = '0;
      n_counts[low] = COUNT_BITS'(counts_i[src] - 1'b1);
      n_counts[dst] = COUNT_BITS'(counts_i[dst] + 1'b1);
    end
  end

  // last when every selected position below the highest one is empty
  always_comb begin
    hi = '0;
    for (int p = 0; p < POSITIONS; p++) begin
      if (n_sel[p]) hi = PW'(p);
    end
    last = 1'b1;
    for (int p = 0; p < POSITIONS; p++) begin
      if (n_sel[p] && PW'(p) != hi && n_counts[p] != '0) last = 1'b0;
    end
  end

  assign counts_o      = n_counts;
  assign sel_o         = n_sel;
  assign active_o      = n_active;
  assign done_o        = err ? done_i : last;
  assign res_o.err     = err;
  assign res_o.is_last = !err && last;

endmodule
